// ----- src/assert_macros.svh -----
// Assertion macros used by point_along_segment
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- src/psa_pkg.sv -----
// Package: widths, register map and side-data types of point_along_segment
package psa_pkg;
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int ROOT_W    = DIFF_W;
   localparam int SQREM_W   = ROOT_W + 4;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int QUO_W     = COORD_W;
   localparam int REM_W     = ROOT_W;
   localparam int OUT_W     = COORD_W + 2;
   localparam int MINLEN_W  = 31;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;
   // front 3, root, threshold stage, divider, output register
   localparam int LATENCY   = 3 + ROOT_W + 1 + QUO_W + 1;

   localparam logic REG_MIN_LENGTH = 1'b0;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] start;
      logic [2:0][PROD_W-1:0]  prod;
      logic [2:0]              neg;
   } psa_side_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] start;
      logic [2:0]              neg;
      logic                    degen;
   } psa_tail_type;
endpackage

// ----- src/psa_sqrt.sv -----
// Pipelined integer square root, one result bit per stage
module psa_sqrt import psa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_rad,
   input  psa_side_type      in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output psa_side_type      out_side
);
   logic               vld  [0:ROOT_W];
   logic [SQ_W-1:0]    rad  [0:ROOT_W];
   logic [SQREM_W-1:0] rem  [0:ROOT_W];
   logic [ROOT_W-1:0]  root [0:ROOT_W];
   psa_side_type       side [0:ROOT_W];

   assign vld[0]  = in_valid;
   assign rad[0]  = in_rad;
   assign rem[0]  = '0;
   assign root[0] = '0;
   assign side[0] = in_side;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic               vld_ff;
      logic [SQ_W-1:0]    rad_ff;
      logic [SQREM_W-1:0] rem_ff;
      logic [ROOT_W-1:0]  root_ff;
      psa_side_type       side_ff;
      logic [SQREM_W-1:0] rem_sh;
      logic [SQREM_W-1:0] trial;
      logic               ge;
      logic [SQREM_W-1:0] rem_in;
      logic [ROOT_W-1:0]  root_in;

      always_comb begin
         rem_sh  = {rem[k][SQREM_W-3:0], rad[k][SQ_W-1 -: 2]};
         trial   = {2'b00, root[k], 2'b01};
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root[k][ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld[k];
         end
         rad_ff  <= {rad[k][SQ_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side[k];
      end

      assign vld[k+1]  = vld_ff;
      assign rad[k+1]  = rad_ff;
      assign rem[k+1]  = rem_ff;
      assign root[k+1] = root_ff;
      assign side[k+1] = side_ff;
   end

   assign out_valid = vld[ROOT_W];
   assign out_root  = root[ROOT_W];
   assign out_side  = side[ROOT_W];
endmodule

// ----- src/psa_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one bit per stage
module psa_div import psa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [ROOT_W-1:0]       in_len,
   input  logic [2:0][PROD_W-1:0]  in_prod,
   input  psa_tail_type            in_tail,
   output logic                    out_valid,
   output logic [2:0][QUO_W-1:0]   out_quo,
   output psa_tail_type            out_tail
);
   logic                   vld  [0:QUO_W];
   logic [ROOT_W-1:0]      len  [0:QUO_W];
   logic [2:0][REM_W-1:0]  rem  [0:QUO_W];
   logic [2:0][QUO_W-1:0]  low  [0:QUO_W];
   logic [2:0][QUO_W-1:0]  quo  [0:QUO_W];
   psa_tail_type           tail [0:QUO_W];

   assign vld[0]  = in_valid;
   assign len[0]  = in_len;
   assign tail[0] = in_tail;
   for (genvar j = 0; j < 3; j++) begin : g_init
      // upper half is below the divisor since the quotient fits QUO_W bits
      assign rem[0][j] = {1'b0, in_prod[j][PROD_W-1:QUO_W]};
      assign low[0][j] = in_prod[j][QUO_W-1:0];
      assign quo[0][j] = '0;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic                   vld_ff;
      logic [ROOT_W-1:0]      len_ff;
      logic [2:0][REM_W-1:0]  rem_ff;
      logic [2:0][QUO_W-1:0]  low_ff;
      logic [2:0][QUO_W-1:0]  quo_ff;
      psa_tail_type           tail_ff;
      logic [2:0][REM_W-1:0]  rem_in;
      logic [2:0][QUO_W-1:0]  quo_in;

      always_comb begin
         logic [REM_W:0] r2;
         logic [REM_W:0] diff;
         for (int j = 0; j < 3; j++) begin
            r2   = {rem[k][j], low[k][j][QUO_W-1]};
            diff = r2 - {1'b0, len[k]};
            if (r2 >= {1'b0, len[k]}) begin
               rem_in[j] = diff[REM_W-1:0];
               quo_in[j] = {quo[k][j][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[j] = r2[REM_W-1:0];
               quo_in[j] = {quo[k][j][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld[k];
         end
         len_ff  <= len[k];
         rem_ff  <= rem_in;
         for (int j = 0; j < 3; j++) begin
            low_ff[j] <= {low[k][j][QUO_W-2:0], 1'b0};
         end
         quo_ff  <= quo_in;
         tail_ff <= tail[k];
      end

      assign vld[k+1]  = vld_ff;
      assign len[k+1]  = len_ff;
      assign rem[k+1]  = rem_ff;
      assign low[k+1]  = low_ff;
      assign quo[k+1]  = quo_ff;
      assign tail[k+1] = tail_ff;
   end

   assign out_valid = vld[QUO_W];
   assign out_quo   = quo[QUO_W];
   assign out_tail  = tail[QUO_W];
endmodule

// ----- src/point_along_segment.sv -----
// Top level: point at a signed distance along a 3D segment, fully pipelined
//
//   channel   ports                          transfer
//   -------   -----------------------------  ------------------------------
//   request   start, busy, req_*             start high and busy low
//   response  rsp_strobe, rsp_*              rsp_strobe high, one cycle
//   csr       psel penable pwrite paddr ...  APB access phase, pready = 1
//
// One request per cycle; each response appears after its request has passed
// 3 front stages (difference, multipliers, sum of squares), 33 root stages, a
// threshold stage, 32 divider stages and the output register.
// busy is always low; the response side cannot stall, so nothing ever backs up.
// Synchronous reset clears every valid bit and sets min_length to 1.
`include "assert_macros.svh"

module point_along_segment import psa_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_start_z,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic signed [COORD_W-1:0] req_end_z,
   input  logic signed [COORD_W-1:0] req_travel,
   // response
   output logic                      rsp_strobe,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [COORD_W-1:0] rsp_point_z,
   output logic                      rsp_degenerate,
   // csr
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);
   // ---------------- csr ----------------
   logic [MINLEN_W-1:0] min_length_ff;
   logic                csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[ADDR_W-1] == REG_MIN_LENGTH);
   assign prdata  = csr_hit ? {{(DATA_W-MINLEN_W){1'b0}}, min_length_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MINLEN_W'(1);
      end else if (psel && penable && pwrite && csr_hit) begin
         min_length_ff <= pwdata[MINLEN_W-1:0];
      end
   end

   // never stalls: one request per cycle
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------- F1: direction vector ----------------
   logic                            f1_vld_ff;
   logic [2:0][COORD_W-1:0]         f1_start_ff;
   logic signed [DIFF_W-1:0]        f1_diff_ff [3];
   logic signed [COORD_W-1:0]       f1_travel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= accept;
      end
      f1_start_ff   <= {req_start_z, req_start_y, req_start_x};
      f1_diff_ff[0] <= DIFF_W'(req_end_x) - DIFF_W'(req_start_x);
      f1_diff_ff[1] <= DIFF_W'(req_end_y) - DIFF_W'(req_start_y);
      f1_diff_ff[2] <= DIFF_W'(req_end_z) - DIFF_W'(req_start_z);
      f1_travel_ff  <= req_travel;
   end

   // ---------------- F2: squares and |d|*|t| ----------------
   logic [DIFF_W-1:0]  mag_d [3];
   logic [COORD_W-1:0] mag_t;
   logic               f2_vld_ff;
   logic [SQ_W-1:0]    f2_sq_ff [3];
   psa_side_type       f2_side_in;
   psa_side_type       f2_side_ff;

   always_comb begin
      logic [DIFF_W+COORD_W-1:0] p;
      mag_t = f1_travel_ff[COORD_W-1] ? (COORD_W'(0) - f1_travel_ff) : f1_travel_ff;
      f2_side_in.start = f1_start_ff;
      for (int j = 0; j < 3; j++) begin
         mag_d[j] = f1_diff_ff[j][DIFF_W-1] ? (DIFF_W'(0) - f1_diff_ff[j]) : f1_diff_ff[j];
         p = mag_d[j] * mag_t;
         // |d| <= 2^32 and |t| <= 2^31, so the top bit is always zero
         f2_side_in.prod[j] = p[PROD_W-1:0];
         f2_side_in.neg[j]  = f1_diff_ff[j][DIFF_W-1] ^ f1_travel_ff[COORD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else begin
         f2_vld_ff <= f1_vld_ff;
      end
      for (int j = 0; j < 3; j++) begin
         f2_sq_ff[j] <= mag_d[j] * mag_d[j];
      end
      f2_side_ff <= f2_side_in;
   end

   // ---------------- F3: sum of squares ----------------
   logic            f3_vld_ff;
   logic [SQ_W-1:0] f3_sum_ff;
   psa_side_type    f3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_vld_ff <= 1'b0;
      end else begin
         f3_vld_ff <= f2_vld_ff;
      end
      // below 3 * 2^64, fits SQ_W
      f3_sum_ff  <= f2_sq_ff[0] + f2_sq_ff[1] + f2_sq_ff[2];
      f3_side_ff <= f2_side_ff;
   end

   // ---------------- length ----------------
   logic              rt_vld;
   logic [ROOT_W-1:0] rt_root;
   psa_side_type      rt_side;

   psa_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f3_vld_ff),
      .in_rad    (f3_sum_ff),
      .in_side   (f3_side_ff),
      .out_valid (rt_vld),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // ---------------- threshold ----------------
   // zero length is degenerate even with a zero threshold
   logic                   th_vld_ff;
   logic [ROOT_W-1:0]      th_len_ff;
   logic [2:0][PROD_W-1:0] th_prod_ff;
   psa_tail_type           th_tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         th_vld_ff <= 1'b0;
      end else begin
         th_vld_ff <= rt_vld;
      end
      th_len_ff        <= rt_root;
      th_prod_ff       <= rt_side.prod;
      th_tail_ff.start <= rt_side.start;
      th_tail_ff.neg   <= rt_side.neg;
      th_tail_ff.degen <= (rt_root == '0) ||
                          (rt_root < {{(ROOT_W-MINLEN_W){1'b0}}, min_length_ff});
   end

   // ---------------- quotient ----------------
   logic                  dv_vld;
   logic [2:0][QUO_W-1:0] dv_quo;
   psa_tail_type          dv_tail;

   psa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (th_vld_ff),
      .in_len    (th_len_ff),
      .in_prod   (th_prod_ff),
      .in_tail   (th_tail_ff),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_tail  (dv_tail)
   );

   // ---------------- offset, saturate, output register ----------------
   logic [2:0][COORD_W-1:0] pt_in;

   always_comb begin
      logic signed [OUT_W-1:0] s;
      logic signed [OUT_W-1:0] q;
      logic signed [OUT_W-1:0] sum;
      for (int j = 0; j < 3; j++) begin
         s   = OUT_W'($signed(dv_tail.start[j]));
         q   = $signed({2'b00, dv_quo[j]});
         sum = dv_tail.neg[j] ? (s - q) : (s + q);
         if (dv_tail.degen) begin
            pt_in[j] = dv_tail.start[j];
         end else if (sum > $signed({3'b000, {(COORD_W-1){1'b1}}})) begin
            pt_in[j] = {1'b0, {(COORD_W-1){1'b1}}};
         end else if (sum < $signed({3'b111, {(COORD_W-1){1'b0}}})) begin
            pt_in[j] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            pt_in[j] = sum[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= dv_vld;
      end
      rsp_point_x    <= pt_in[0];
      rsp_point_y    <= pt_in[1];
      rsp_point_z    <= pt_in[2];
      rsp_degenerate <= dv_tail.degen;
   end

   // ---------------- assertions ----------------
   // every accepted request comes out as a response once it has passed the whole pipeline
   `ASSERT_NEXT(a_latency, clock, reset, accept, ##(LATENCY-1) rsp_strobe)
   // no response without an accepted request that has passed the whole pipeline
   `ASSERT_IMPL(a_no_phantom, clock, reset, rsp_strobe, $past(accept, LATENCY))
   // a degenerate response echoes the start point of its request
   `ASSERT_IMPL(a_degen_echo, clock, reset, rsp_strobe && rsp_degenerate,
                (rsp_point_x == $past(req_start_x, LATENCY)) &&
                (rsp_point_y == $past(req_start_y, LATENCY)) &&
                (rsp_point_z == $past(req_start_z, LATENCY)))
endmodule
